### rtl/tsua_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsua_pkg
// Shared types, constants and helpers of the tilt-shift unstretch accumulator.
// ----------------------------------------------------------------------------
package tsua_pkg;

    localparam int SHIFT_W    = 24;
    localparam int TILT_W     = 16;
    localparam int AXIS_W     = 17;
    localparam int ANG_W      = 18;     // doubled axis angle
    localparam int TRIG_W     = 33;     // Q30 cos/sin with headroom
    localparam int Z_W        = 26;     // CORDIC residual angle, degree*2^16
    localparam int CORDIC_N   = 16;
    localparam int NUM_W      = 53;     // divider dividend
    localparam int DEN_W      = 41;     // divider divisor
    localparam int SAT_W      = 57;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);
    localparam logic signed [TRIG_W-1:0] COS_MIN     = TRIG_W'(4194304);
    localparam logic signed [DEN_W-1:0]  DET_MIN     = DEN_W'(16);
    localparam int FULL_TURN    = 92160;
    localparam int HALF_TURN    = 46080;
    localparam int QUARTER_TURN = 23040;

    localparam logic signed [SHIFT_W-1:0] W24_MAX = 24'sh7FFFFF;
    localparam logic signed [SHIFT_W-1:0] W24_MIN = 24'sh800000;

    typedef enum logic [0:0] {
        REG_ZT_X = 1'b0,
        REG_ZT_Y = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        TRIG_REF  = 2'd0,
        TRIG_TILT = 2'd1,
        TRIG_AXIS = 2'd2
    } trig_sel_t;

    typedef enum logic [1:0] {
        DIV_S = 2'd0,
        DIV_X = 2'd1,
        DIV_Y = 2'd2
    } div_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TREF_GO,
        ST_TREF_WAIT,
        ST_TTILT_GO,
        ST_TTILT_WAIT,
        ST_TAXIS_GO,
        ST_TAXIS_WAIT,
        ST_CHECK,
        ST_DIVS_GO,
        ST_DIVS_WAIT,
        ST_PM,
        ST_MUL,
        ST_SUM,
        ST_PROD,
        ST_DET,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic      load;
        logic      trig_go;
        trig_sel_t trig_sel;
        logic      trig_store;
        logic      div_go;
        div_sel_t  div_sel;
        logic      div_store;
        logic      step_pm;
        logic      step_mul;
        logic      step_sum;
        logic      step_prod;
        logic      step_det;
        logic      commit;
    } cmd_t;

    typedef struct packed {
        logic trig_done;
        logic div_done;
        logic cos_small;
    } stat_t;

    function automatic logic [21:0] atan_lut(input logic [3:0] i);
        logic [21:0] v;
        begin
            case (i)
                4'd0:    v = 22'd2949120;
                4'd1:    v = 22'd1740967;
                4'd2:    v = 22'd919879;
                4'd3:    v = 22'd466945;
                4'd4:    v = 22'd234379;
                4'd5:    v = 22'd117304;
                4'd6:    v = 22'd58666;
                4'd7:    v = 22'd29335;
                4'd8:    v = 22'd14668;
                4'd9:    v = 22'd7334;
                4'd10:   v = 22'd3667;
                4'd11:   v = 22'd1833;
                4'd12:   v = 22'd917;
                4'd13:   v = 22'd458;
                4'd14:   v = 22'd229;
                default: v = 22'd115;
            endcase
            return v;
        end
    endfunction

    function automatic logic ovf24(input logic signed [SAT_W-1:0] v);
        return (v > SAT_W'(W24_MAX)) || (v < SAT_W'(W24_MIN));
    endfunction

    function automatic logic signed [SHIFT_W-1:0] sat24(input logic signed [SAT_W-1:0] v);
        logic signed [SHIFT_W-1:0] r;
        begin
            if (v > SAT_W'(W24_MAX))
                r = W24_MAX;
            else if (v < SAT_W'(W24_MIN))
                r = W24_MIN;
            else
                r = v[SHIFT_W-1:0];
            return r;
        end
    endfunction

endpackage

### rtl/tsua_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsua_frame_if / tsua_result_if
// Valid/ready channels for frame beats and result beats.
// ----------------------------------------------------------------------------
interface tsua_frame_if;
    logic                                        valid;
    logic                                        ready;
    logic                                        restart;
    logic signed [tsua_pkg::TILT_W-1:0]          ref_tilt;
    logic signed [tsua_pkg::TILT_W-1:0]          frame_tilt;
    logic signed [tsua_pkg::AXIS_W-1:0]          axis_angle;
    logic signed [tsua_pkg::SHIFT_W-1:0]         meas_shift_x;
    logic signed [tsua_pkg::SHIFT_W-1:0]         meas_shift_y;
    logic signed [tsua_pkg::SHIFT_W-1:0]         prior_shift_x;
    logic signed [tsua_pkg::SHIFT_W-1:0]         prior_shift_y;

    modport source (output valid, restart, ref_tilt, frame_tilt, axis_angle,
                    meas_shift_x, meas_shift_y, prior_shift_x, prior_shift_y,
                    input ready);
    modport sink   (input valid, restart, ref_tilt, frame_tilt, axis_angle,
                    meas_shift_x, meas_shift_y, prior_shift_x, prior_shift_y,
                    output ready);
endinterface

interface tsua_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [tsua_pkg::SHIFT_W-1:0] new_shift_x;
    logic signed [tsua_pkg::SHIFT_W-1:0] new_shift_y;
    logic signed [tsua_pkg::SHIFT_W-1:0] sum_out_x;
    logic signed [tsua_pkg::SHIFT_W-1:0] sum_out_y;
    logic                                overflow;

    modport source (output valid, new_shift_x, new_shift_y, sum_out_x, sum_out_y,
                    overflow, input ready);
    modport sink   (input valid, new_shift_x, new_shift_y, sum_out_x, sum_out_y,
                    overflow, output ready);
endinterface

### rtl/tsua_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsua_cordic
// Rotation-mode CORDIC, one iteration per cycle, cos/sin in Q30.
// ----------------------------------------------------------------------------
module tsua_cordic
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [tsua_pkg::ANG_W-1:0]      angle,
    output logic                                   done,
    output logic signed [tsua_pkg::TRIG_W-1:0]     cos_q30,
    output logic signed [tsua_pkg::TRIG_W-1:0]     sin_q30
);

    localparam int R_W = 20;

    logic                                busy_reg;
    logic                                done_reg;
    logic [3:0]                          cnt_reg;
    logic                                neg_reg;
    logic signed [tsua_pkg::TRIG_W-1:0]  x_reg;
    logic signed [tsua_pkg::TRIG_W-1:0]  y_reg;
    logic signed [tsua_pkg::Z_W-1:0]     z_reg;

    logic signed [R_W-1:0]               r0, r1, r2, r3;
    logic                                fold_neg;
    logic signed [tsua_pkg::Z_W-1:0]     z_init;
    logic signed [tsua_pkg::TRIG_W-1:0]  dx, dy;
    logic signed [tsua_pkg::Z_W-1:0]     at;

    // reduce into [-180,180) then fold into [-90,90]
    always_comb
    begin
        r0 = R_W'(angle);
        if (r0 >= R_W'(tsua_pkg::HALF_TURN))
            r1 = r0 - R_W'(tsua_pkg::FULL_TURN);
        else if (r0 < -R_W'(tsua_pkg::HALF_TURN))
            r1 = r0 + R_W'(tsua_pkg::FULL_TURN);
        else
            r1 = r0;
        if (r1 >= R_W'(tsua_pkg::HALF_TURN))
            r2 = r1 - R_W'(tsua_pkg::FULL_TURN);
        else if (r1 < -R_W'(tsua_pkg::HALF_TURN))
            r2 = r1 + R_W'(tsua_pkg::FULL_TURN);
        else
            r2 = r1;
        fold_neg = 1'b0;
        if (r2 > R_W'(tsua_pkg::QUARTER_TURN))
        begin
            r3       = r2 - R_W'(tsua_pkg::HALF_TURN);
            fold_neg = 1'b1;
        end
        else if (r2 < -R_W'(tsua_pkg::QUARTER_TURN))
        begin
            r3       = r2 + R_W'(tsua_pkg::HALF_TURN);
            fold_neg = 1'b1;
        end
        else
        begin
            r3 = r2;
        end
        z_init = tsua_pkg::Z_W'(r3) <<< 8;
    end

    always_comb
    begin
        dx = y_reg >>> cnt_reg;
        dy = x_reg >>> cnt_reg;
        at = tsua_pkg::Z_W'(tsua_pkg::atan_lut(cnt_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(tsua_pkg::CORDIC_N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= tsua_pkg::CORDIC_GAIN;
            y_reg   <= '0;
            z_reg   <= z_init;
            neg_reg <= fold_neg;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done    = done_reg;
    assign cos_q30 = neg_reg ? -x_reg : x_reg;
    assign sin_q30 = neg_reg ? -y_reg : y_reg;

endmodule

### rtl/tsua_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsua_div
// Signed restoring divider, one quotient bit per cycle, truncates toward 0.
// ----------------------------------------------------------------------------
module tsua_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [tsua_pkg::NUM_W-1:0]    num,
    input  logic signed [tsua_pkg::DEN_W-1:0]    den,
    output logic                                 done,
    output logic signed [tsua_pkg::NUM_W:0]      quo
);

    localparam int NW  = tsua_pkg::NUM_W;
    localparam int DW  = tsua_pkg::DEN_W;
    localparam int CW  = $clog2(NW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic            neg_reg;
    logic [NW-1:0]   q_reg;
    logic [DW-1:0]   r_reg;
    logic [DW-1:0]   d_reg;

    logic [DW:0]     sh;
    logic            ge;
    logic [NW-1:0]   nmag;
    logic [DW-1:0]   dmag;

    always_comb
    begin
        nmag = num[NW-1] ? NW'(-num) : NW'(num);
        dmag = den[DW-1] ? DW'(-den) : DW'(den);
        sh   = {r_reg, q_reg[NW-1]};
        ge   = sh >= {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= nmag;
            r_reg   <= '0;
            d_reg   <= dmag;
            neg_reg <= num[NW-1] ^ den[DW-1];
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[NW-2:0], ge};
            r_reg <= ge ? DW'(sh - {1'b0, d_reg}) : sh[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

### rtl/tsua_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsua_dp
// Datapath: accumulate, trig, stretch matrix, inverse and result registers.
// ----------------------------------------------------------------------------
module tsua_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tsua_pkg::cmd_t                        cmd,
    output tsua_pkg::stat_t                       stat,
    input  logic                                  restart,
    input  logic signed [tsua_pkg::TILT_W-1:0]    ref_tilt,
    input  logic signed [tsua_pkg::TILT_W-1:0]    frame_tilt,
    input  logic signed [tsua_pkg::AXIS_W-1:0]    axis_angle,
    input  logic signed [tsua_pkg::SHIFT_W-1:0]   meas_shift_x,
    input  logic signed [tsua_pkg::SHIFT_W-1:0]   meas_shift_y,
    input  logic signed [tsua_pkg::SHIFT_W-1:0]   prior_shift_x,
    input  logic signed [tsua_pkg::SHIFT_W-1:0]   prior_shift_y,
    input  logic signed [tsua_pkg::SHIFT_W-1:0]   zero_tilt_shift_x,
    input  logic signed [tsua_pkg::SHIFT_W-1:0]   zero_tilt_shift_y,
    output logic signed [tsua_pkg::SHIFT_W-1:0]   new_shift_x,
    output logic signed [tsua_pkg::SHIFT_W-1:0]   new_shift_y,
    output logic signed [tsua_pkg::SHIFT_W-1:0]   sum_out_x,
    output logic signed [tsua_pkg::SHIFT_W-1:0]   sum_out_y,
    output logic                                  overflow
);

    localparam int SW = tsua_pkg::SHIFT_W;
    localparam int TW = tsua_pkg::TRIG_W;
    localparam int QW = tsua_pkg::NUM_W + 1;
    localparam int SQ_W = 27;           // S in Q16
    localparam int PM_W = 28;
    localparam int CS_W = TW - 14;      // cos/sin of doubled axis in Q16
    localparam int MP_W = PM_W + CS_W;
    localparam int A_W  = 28;
    localparam int PP_W = 2 * A_W;
    localparam int XP_W = SW + A_W;

    // frame and running sums
    logic signed [SW-1:0]  sum_x_reg, sum_y_reg;
    logic signed [SW-1:0]  px_reg, py_reg;
    logic signed [SW-1:0]  sx_reg, sy_reg;
    logic                  flag_reg;
    logic signed [SW-1:0]  nx_reg, ny_reg;

    // angles held for the whole frame, the input beat is gone after load
    logic signed [tsua_pkg::TILT_W-1:0] rt_reg, ft_reg;
    logic signed [tsua_pkg::AXIS_W-1:0] ax_reg;

    logic signed [TW-1:0]  cr_reg, ct_reg, c2_reg, s2_reg;
    logic signed [SQ_W-1:0] s_reg;
    logic signed [CS_W-1:0] cq_reg, sq_reg;
    logic signed [PM_W-1:0] p_reg, m_reg;
    logic signed [MP_W-1:0] mc_prod_reg, ms_prod_reg;
    logic signed [A_W-1:0]  a0_reg, a1_reg, a2_reg;
    logic signed [PP_W-1:0] p02_reg, p11_reg;
    logic signed [XP_W-1:0] px2_reg, py1_reg, py0_reg, px1_reg;
    logic signed [tsua_pkg::DEN_W-1:0] det_reg;
    logic signed [tsua_pkg::NUM_W-1:0] numx_reg, numy_reg;

    logic signed [SW-1:0]  nsx_reg, nsy_reg, osx_reg, osy_reg;
    logic                  ovf_reg;

    // accumulate
    logic signed [SW-1:0]  base_x, base_y;
    logic signed [SW+1:0]  acc_x, acc_y;

    // trig unit
    logic signed [tsua_pkg::ANG_W-1:0] trig_ang;
    logic                              trig_done;
    logic signed [TW-1:0]              trig_cos, trig_sin;

    // divider
    logic signed [tsua_pkg::NUM_W-1:0] div_num;
    logic signed [tsua_pkg::DEN_W-1:0] div_den;
    logic                              div_done;
    logic signed [QW-1:0]              div_q;
    logic                              det_small;
    logic signed [tsua_pkg::NUM_W-1:0] cur_num;
    logic signed [SW-1:0]              div_res;
    logic                              div_ovf;

    logic                              cos_small;
    logic signed [SW-1:0]              fx, fy;
    logic signed [SW:0]                ox, oy;

    always_comb
    begin
        base_x = restart ? '0 : sum_x_reg;
        base_y = restart ? '0 : sum_y_reg;
        acc_x  = (SW+2)'(base_x) + (SW+2)'(meas_shift_x) - (SW+2)'(zero_tilt_shift_x);
        acc_y  = (SW+2)'(base_y) + (SW+2)'(meas_shift_y) - (SW+2)'(zero_tilt_shift_y);
    end

    always_comb
    begin
        case (cmd.trig_sel)
            tsua_pkg::TRIG_REF:  trig_ang = tsua_pkg::ANG_W'(rt_reg);
            tsua_pkg::TRIG_TILT: trig_ang = tsua_pkg::ANG_W'(ft_reg);
            default:             trig_ang = {ax_reg, 1'b0};
        endcase
    end

    tsua_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.trig_go),
        .angle   (trig_ang),
        .done    (trig_done),
        .cos_q30 (trig_cos),
        .sin_q30 (trig_sin)
    );

    always_comb
    begin
        case (cmd.div_sel)
            tsua_pkg::DIV_S:
            begin
                div_num = tsua_pkg::NUM_W'(cr_reg) <<< 16;
                div_den = tsua_pkg::DEN_W'(ct_reg);
            end
            tsua_pkg::DIV_X:
            begin
                div_num = numx_reg;
                div_den = det_reg;
            end
            default:
            begin
                div_num = numy_reg;
                div_den = det_reg;
            end
        endcase
    end

    tsua_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    // near-zero determinant saturates toward the sign of num*det
    always_comb
    begin
        det_small = (det_reg < tsua_pkg::DET_MIN) && (det_reg > -tsua_pkg::DET_MIN);
        cur_num   = (cmd.div_sel == tsua_pkg::DIV_X) ? numx_reg : numy_reg;
        if (det_small)
        begin
            div_ovf = 1'b1;
            if (cur_num == 0)
                div_res = '0;
            else if ((cur_num > 0) == (det_reg > 0))
                div_res = tsua_pkg::W24_MAX;
            else
                div_res = tsua_pkg::W24_MIN;
        end
        else
        begin
            div_ovf = tsua_pkg::ovf24(tsua_pkg::SAT_W'(div_q));
            div_res = tsua_pkg::sat24(tsua_pkg::SAT_W'(div_q));
        end
    end

    always_comb
    begin
        cos_small = (ct_reg < tsua_pkg::COS_MIN) && (ct_reg > -tsua_pkg::COS_MIN);
        fx = cos_small ? sx_reg : nx_reg;
        fy = cos_small ? sy_reg : ny_reg;
        ox = (SW+1)'(px_reg) + (SW+1)'(fx);
        oy = (SW+1)'(py_reg) + (SW+1)'(fy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else if (cmd.commit)
        begin
            sum_x_reg <= fx;
            sum_y_reg <= fy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg   <= prior_shift_x;
            py_reg   <= prior_shift_y;
            rt_reg   <= ref_tilt;
            ft_reg   <= frame_tilt;
            ax_reg   <= axis_angle;
            sx_reg   <= tsua_pkg::sat24(tsua_pkg::SAT_W'(acc_x));
            sy_reg   <= tsua_pkg::sat24(tsua_pkg::SAT_W'(acc_y));
            flag_reg <= tsua_pkg::ovf24(tsua_pkg::SAT_W'(acc_x))
                      | tsua_pkg::ovf24(tsua_pkg::SAT_W'(acc_y));
        end
        else if (cmd.div_store && (cmd.div_sel != tsua_pkg::DIV_S))
        begin
            flag_reg <= flag_reg | div_ovf;
        end

        if (cmd.trig_store)
        begin
            case (cmd.trig_sel)
                tsua_pkg::TRIG_REF:  cr_reg <= trig_cos;
                tsua_pkg::TRIG_TILT: ct_reg <= trig_cos;
                default:
                begin
                    c2_reg <= trig_cos;
                    s2_reg <= trig_sin;
                end
            endcase
        end

        if (cmd.div_store)
        begin
            case (cmd.div_sel)
                tsua_pkg::DIV_S: s_reg  <= div_q[SQ_W-1:0];
                tsua_pkg::DIV_X: nx_reg <= div_res;
                default:         ny_reg <= div_res;
            endcase
        end

        if (cmd.step_pm)
        begin
            cq_reg <= CS_W'(c2_reg >>> 14);
            sq_reg <= CS_W'(s2_reg >>> 14);
            p_reg  <= (PM_W'(s_reg) + PM_W'(65536)) >>> 1;
            m_reg  <= (PM_W'(s_reg) - PM_W'(65536)) >>> 1;
        end

        if (cmd.step_mul)
        begin
            mc_prod_reg <= MP_W'(m_reg) * MP_W'(cq_reg);
            ms_prod_reg <= MP_W'(m_reg) * MP_W'(sq_reg);
        end

        if (cmd.step_sum)
        begin
            a0_reg <= A_W'(p_reg) + A_W'(mc_prod_reg >>> 16);
            a1_reg <= A_W'(ms_prod_reg >>> 16);
            a2_reg <= A_W'(p_reg) - A_W'(mc_prod_reg >>> 16);
        end

        if (cmd.step_prod)
        begin
            p02_reg <= PP_W'(a0_reg) * PP_W'(a2_reg);
            p11_reg <= PP_W'(a1_reg) * PP_W'(a1_reg);
            px2_reg <= XP_W'(sx_reg) * XP_W'(a2_reg);
            py1_reg <= XP_W'(sy_reg) * XP_W'(a1_reg);
            py0_reg <= XP_W'(sy_reg) * XP_W'(a0_reg);
            px1_reg <= XP_W'(sx_reg) * XP_W'(a1_reg);
        end

        if (cmd.step_det)
        begin
            det_reg  <= tsua_pkg::DEN_W'(((PP_W+1)'(p02_reg) - (PP_W+1)'(p11_reg)) >>> 16);
            numx_reg <= tsua_pkg::NUM_W'(px2_reg) - tsua_pkg::NUM_W'(py1_reg);
            numy_reg <= tsua_pkg::NUM_W'(py0_reg) - tsua_pkg::NUM_W'(px1_reg);
        end

        if (cmd.commit)
        begin
            nsx_reg <= tsua_pkg::sat24(tsua_pkg::SAT_W'(ox));
            nsy_reg <= tsua_pkg::sat24(tsua_pkg::SAT_W'(oy));
            osx_reg <= fx;
            osy_reg <= fy;
            ovf_reg <= flag_reg | cos_small
                     | tsua_pkg::ovf24(tsua_pkg::SAT_W'(ox))
                     | tsua_pkg::ovf24(tsua_pkg::SAT_W'(oy));
        end
    end

    assign stat.trig_done = trig_done;
    assign stat.div_done  = div_done;
    assign stat.cos_small = cos_small;

    assign new_shift_x = nsx_reg;
    assign new_shift_y = nsy_reg;
    assign sum_out_x   = osx_reg;
    assign sum_out_y   = osy_reg;
    assign overflow    = ovf_reg;

endmodule

### rtl/tsua_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsua_ctrl
// Sequencer for one frame and owner of the frame/result handshakes.
// ----------------------------------------------------------------------------
module tsua_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_valid,
    output logic             frame_ready,
    output logic             result_valid,
    input  logic             result_ready,
    input  tsua_pkg::stat_t  stat,
    output tsua_pkg::cmd_t   cmd
);

    tsua_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsua_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.trig_sel   = tsua_pkg::TRIG_REF;
        cmd.div_sel    = tsua_pkg::DIV_S;

        if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            tsua_pkg::ST_IDLE:
            begin
                if (frame_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = tsua_pkg::ST_TREF_GO;
                end
            end
            tsua_pkg::ST_TREF_GO:
            begin
                cmd.trig_go = 1'b1;
                state_next  = tsua_pkg::ST_TREF_WAIT;
            end
            tsua_pkg::ST_TREF_WAIT:
            begin
                if (stat.trig_done)
                begin
                    cmd.trig_store = 1'b1;
                    state_next     = tsua_pkg::ST_TTILT_GO;
                end
            end
            tsua_pkg::ST_TTILT_GO:
            begin
                cmd.trig_sel = tsua_pkg::TRIG_TILT;
                cmd.trig_go  = 1'b1;
                state_next   = tsua_pkg::ST_TTILT_WAIT;
            end
            tsua_pkg::ST_TTILT_WAIT:
            begin
                cmd.trig_sel = tsua_pkg::TRIG_TILT;
                if (stat.trig_done)
                begin
                    cmd.trig_store = 1'b1;
                    state_next     = tsua_pkg::ST_TAXIS_GO;
                end
            end
            tsua_pkg::ST_TAXIS_GO:
            begin
                cmd.trig_sel = tsua_pkg::TRIG_AXIS;
                cmd.trig_go  = 1'b1;
                state_next   = tsua_pkg::ST_TAXIS_WAIT;
            end
            tsua_pkg::ST_TAXIS_WAIT:
            begin
                cmd.trig_sel = tsua_pkg::TRIG_AXIS;
                if (stat.trig_done)
                begin
                    cmd.trig_store = 1'b1;
                    state_next     = tsua_pkg::ST_CHECK;
                end
            end
            tsua_pkg::ST_CHECK:
            begin
                // tilt cosine near zero: sum passes through unchanged
                state_next = stat.cos_small ? tsua_pkg::ST_COMMIT : tsua_pkg::ST_DIVS_GO;
            end
            tsua_pkg::ST_DIVS_GO:
            begin
                cmd.div_go = 1'b1;
                state_next = tsua_pkg::ST_DIVS_WAIT;
            end
            tsua_pkg::ST_DIVS_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = tsua_pkg::ST_PM;
                end
            end
            tsua_pkg::ST_PM:
            begin
                cmd.step_pm = 1'b1;
                state_next  = tsua_pkg::ST_MUL;
            end
            tsua_pkg::ST_MUL:
            begin
                cmd.step_mul = 1'b1;
                state_next   = tsua_pkg::ST_SUM;
            end
            tsua_pkg::ST_SUM:
            begin
                cmd.step_sum = 1'b1;
                state_next   = tsua_pkg::ST_PROD;
            end
            tsua_pkg::ST_PROD:
            begin
                cmd.step_prod = 1'b1;
                state_next    = tsua_pkg::ST_DET;
            end
            tsua_pkg::ST_DET:
            begin
                cmd.step_det = 1'b1;
                state_next   = tsua_pkg::ST_DIVX_GO;
            end
            tsua_pkg::ST_DIVX_GO:
            begin
                cmd.div_sel = tsua_pkg::DIV_X;
                cmd.div_go  = 1'b1;
                state_next  = tsua_pkg::ST_DIVX_WAIT;
            end
            tsua_pkg::ST_DIVX_WAIT:
            begin
                cmd.div_sel = tsua_pkg::DIV_X;
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = tsua_pkg::ST_DIVY_GO;
                end
            end
            tsua_pkg::ST_DIVY_GO:
            begin
                cmd.div_sel = tsua_pkg::DIV_Y;
                cmd.div_go  = 1'b1;
                state_next  = tsua_pkg::ST_DIVY_WAIT;
            end
            tsua_pkg::ST_DIVY_WAIT:
            begin
                cmd.div_sel = tsua_pkg::DIV_Y;
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = tsua_pkg::ST_COMMIT;
                end
            end
            tsua_pkg::ST_COMMIT:
            begin
                // result register must be free or emptied this cycle
                if (!out_valid_reg || result_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = tsua_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsua_pkg::ST_IDLE;
            end
        endcase
    end

    assign frame_ready  = (state_reg == tsua_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

### rtl/tilt_shift_unstretch_accumulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_shift_unstretch_accumulator_core
// Accumulates zero-tilt-corrected frame shifts and unstretches the running
// sum with the inverse tilt stretch matrix, one frame per beat.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | content
//  frame    | in  | valid/ready   | restart, tilts, axis, measured/prior shift
//  result   | out | valid/ready   | new shift, running sum, overflow
//  apb      | in  | psel/penable  | zero_tilt_shift_x @0x0, zero_tilt_shift_y @0x4
//
// A frame takes three 16-step CORDIC runs on one shared unit and three
// divides on one shared 1-bit-per-cycle divider.
// With a near-zero tilt cosine the divides are skipped.
// frame.ready is high only between frames; a new frame is taken while the
// previous result still waits in the result register.
// Reset clears the running sums, the zero-tilt shift registers and the handshake state at once.
// ----------------------------------------------------------------------------
module tilt_shift_unstretch_accumulator_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    tsua_frame_if.sink                           frame,
    tsua_result_if.source                        result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tsua_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [tsua_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [tsua_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    localparam int SW = tsua_pkg::SHIFT_W;
    localparam int DW = tsua_pkg::CFG_DATA_W;

    logic signed [SW-1:0]   zt_x_reg, zt_y_reg;
    tsua_pkg::reg_idx_t     reg_idx;
    tsua_pkg::cmd_t         cmd;
    tsua_pkg::stat_t        stat;

    assign pready  = 1'b1;
    assign reg_idx = tsua_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zt_x_reg <= '0;
            zt_y_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                tsua_pkg::REG_ZT_X: zt_x_reg <= pwdata[SW-1:0];
                tsua_pkg::REG_ZT_Y: zt_y_reg <= pwdata[SW-1:0];
                default:            zt_x_reg <= zt_x_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            tsua_pkg::REG_ZT_X: prdata = DW'(zt_x_reg);
            tsua_pkg::REG_ZT_Y: prdata = DW'(zt_y_reg);
            default:            prdata = '0;
        endcase
    end

    tsua_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame.valid),
        .frame_ready  (frame.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    tsua_dp u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .restart           (frame.restart),
        .ref_tilt          (frame.ref_tilt),
        .frame_tilt        (frame.frame_tilt),
        .axis_angle        (frame.axis_angle),
        .meas_shift_x      (frame.meas_shift_x),
        .meas_shift_y      (frame.meas_shift_y),
        .prior_shift_x     (frame.prior_shift_x),
        .prior_shift_y     (frame.prior_shift_y),
        .zero_tilt_shift_x (zt_x_reg),
        .zero_tilt_shift_y (zt_y_reg),
        .new_shift_x       (result.new_shift_x),
        .new_shift_y       (result.new_shift_y),
        .sum_out_x         (result.sum_out_x),
        .sum_out_y         (result.sum_out_y),
        .overflow          (result.overflow)
    );

endmodule
